// ----- sv/md5_pkg.sv -----
// md5_pkg: shared types, constants and round functions for the MD5 digest block.
// No dependencies; used by md5_ctrl, md5_datapath and md5_message_digest.
package md5_pkg;

    localparam logic [31:0] MD5_IV_A = 32'h67452301;
    localparam logic [31:0] MD5_IV_B = 32'hefcdab89;
    localparam logic [31:0] MD5_IV_C = 32'h98badcfe;
    localparam logic [31:0] MD5_IV_D = 32'h10325476;

    localparam logic [7:0] PAD_BYTE      = 8'h80;
    localparam logic [5:0] LAST_FILL     = 6'd63;
    localparam logic [5:0] PAD_TWO_FILL  = 6'd56;
    localparam logic [4:0] ZERO_END_ONE  = 5'd14;
    localparam logic [4:0] ZERO_END_FULL = 5'd16;
    localparam logic [5:0] LAST_ROUND    = 6'd63;
    localparam logic [3:0] LEN_LO_WORD   = 4'd14;
    localparam logic [3:0] LEN_HI_WORD   = 4'd15;
    localparam logic [1:0] LAST_INDEX    = 2'd3;

    localparam logic [31:0] MD5_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_PAD,
        ST_ZERO,
        ST_LEN,
        ST_RUN,
        ST_FOLD
    } md5_state_t;

    // where the sequencer goes once a compression has been folded in
    typedef enum logic [1:0] {
        AFTER_IDLE,
        AFTER_PAD,
        AFTER_ZERO,
        AFTER_FIN
    } md5_after_t;

    typedef struct packed {
        logic       wr_byte;
        logic       pad_word;
        logic       zero_word;
        logic       len_words;
        logic       step;
        logic       fold;
        logic       final_fold;
        logic [5:0] rnd;
        logic [3:0] word;
    } md5_cmd_t;

    typedef struct packed {
        logic [5:0] fill;
        logic       emit_busy;
    } md5_status_t;

    function automatic logic [4:0] md5_rot(input logic [5:0] rnd);
        logic [3:0] sel;
        logic [4:0] s;
        sel = {rnd[5:4], rnd[1:0]};
        case (sel)
            4'd0:    s = 5'd7;
            4'd1:    s = 5'd12;
            4'd2:    s = 5'd17;
            4'd3:    s = 5'd22;
            4'd4:    s = 5'd5;
            4'd5:    s = 5'd9;
            4'd6:    s = 5'd14;
            4'd7:    s = 5'd20;
            4'd8:    s = 5'd4;
            4'd9:    s = 5'd11;
            4'd10:   s = 5'd16;
            4'd11:   s = 5'd23;
            4'd12:   s = 5'd6;
            4'd13:   s = 5'd10;
            4'd14:   s = 5'd15;
            default: s = 5'd21;
        endcase
        return s;
    endfunction

    function automatic logic [3:0] md5_msg_idx(input logic [5:0] rnd);
        logic [3:0] i;
        logic [3:0] g;
        i = rnd[3:0];
        case (rnd[5:4])
            2'd0:    g = i;
            2'd1:    g = 4'(i * 4'd5 + 4'd1);
            2'd2:    g = 4'(i * 4'd3 + 4'd5);
            default: g = 4'(i * 4'd7);
        endcase
        return g;
    endfunction

    function automatic logic [31:0] md5_round_f(input logic [1:0] r, input logic [31:0] b,
                                                input logic [31:0] c, input logic [31:0] d);
        logic [31:0] f;
        case (r)
            2'd0:    f = (b & c) | (~b & d);
            2'd1:    f = (b & d) | (c & ~d);
            2'd2:    f = b ^ c ^ d;
            default: f = c ^ (b | ~d);
        endcase
        return f;
    endfunction

    function automatic logic [31:0] md5_rotl(input logic [31:0] x, input logic [4:0] s);
        logic [63:0] t;
        t = {x, x} << s;
        return t[63:32];
    endfunction

endpackage

// ----- sv/md5_if.sv -----
// md5_if: valid/ready channel interfaces for message bytes and digest words.
// No dependencies.
interface md5_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       byte_valid;
    logic       last;

    modport source (output valid, data_byte, byte_valid, last, input ready);
    modport sink   (input valid, data_byte, byte_valid, last, output ready);
endinterface

interface md5_word_if;
    logic        valid;
    logic        ready;
    logic [31:0] digest_word;
    logic [1:0]  word_index;
    logic        last_word;

    modport source (output valid, digest_word, word_index, last_word, input ready);
    modport sink   (input valid, digest_word, word_index, last_word, output ready);
endinterface

// ----- sv/md5_message_digest.sv -----
// md5_message_digest: top level of the byte-stream MD5 digest engine.
// Depends on md5_pkg, md5_if, md5_ctrl and md5_datapath.
//
// Message bytes enter on msg, one transfer per cycle while the current 64-byte
// block is filling. The transfer that completes a block starts a compression:
// 64 rounds through the single round unit and then a feed-forward fold, while
// the input stalls. A transfer with last set adds padding (the 0x80 word, each
// zero word, a step to leave the zero fill, then the length words) and a final
// compression, preceded by one more compression when the padding spills into a
// second block or the last byte completes a block. The four digest words, A first,
// leave on digest from an output buffer, one per cycle while ready is high; the
// next message is accepted while they drain, but its final compression waits
// until the previous digest has left. An item with byte_valid low and last low
// is accepted and does nothing.
module md5_message_digest (
    input logic        clk,
    input logic        rst_n,
    md5_byte_if.sink   msg,
    md5_word_if.source digest
);
    import md5_pkg::*;

    md5_cmd_t    cmd;
    md5_status_t sts;

    md5_ctrl u_ctrl (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (msg.valid),
        .in_byte_valid (msg.byte_valid),
        .in_last       (msg.last),
        .in_ready      (msg.ready),
        .sts           (sts),
        .cmd           (cmd)
    );

    md5_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .data_byte (msg.data_byte),
        .cmd       (cmd),
        .sts       (sts),
        .digest    (digest)
    );

endmodule

// ----- sv/md5_ctrl.sv -----
// md5_ctrl: sequencer for byte intake, padding, the 64 compression rounds and fold.
// Depends on md5_pkg.
module md5_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               in_valid,
    input  logic               in_byte_valid,
    input  logic               in_last,
    output logic               in_ready,
    input  md5_pkg::md5_status_t sts,
    output md5_pkg::md5_cmd_t    cmd
);
    import md5_pkg::*;

    md5_state_t state_reg, state_next;
    md5_after_t after_reg, after_next;
    logic [5:0] rnd_reg, rnd_next;
    logic [4:0] pw_reg, pw_next;
    logic       two_reg, two_next;
    logic [4:0] zero_end;

    assign zero_end = two_reg ? ZERO_END_FULL : ZERO_END_ONE;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            after_reg <= AFTER_IDLE;
            rnd_reg   <= '0;
            pw_reg    <= '0;
            two_reg   <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            after_reg <= after_next;
            rnd_reg   <= rnd_next;
            pw_reg    <= pw_next;
            two_reg   <= two_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        after_next = after_reg;
        rnd_next   = rnd_reg;
        pw_next    = pw_reg;
        two_next   = two_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (in_byte_valid && sts.fill == LAST_FILL)
                    begin
                        state_next = ST_RUN;
                        rnd_next   = '0;
                        after_next = in_last ? AFTER_PAD : AFTER_IDLE;
                    end
                    else if (in_last)
                    begin
                        state_next = ST_PAD;
                    end
                end
            end
            ST_PAD:
            begin
                pw_next    = {1'b0, sts.fill[5:2]} + 5'd1;
                two_next   = sts.fill >= PAD_TWO_FILL;
                state_next = ST_ZERO;
            end
            ST_ZERO:
            begin
                if (pw_reg < zero_end)
                begin
                    pw_next = pw_reg + 5'd1;
                end
                else if (two_reg)
                begin
                    state_next = ST_RUN;
                    rnd_next   = '0;
                    after_next = AFTER_ZERO;
                end
                else
                begin
                    state_next = ST_LEN;
                end
            end
            ST_LEN:
            begin
                // digest buffer must be free before the final fold
                if (!sts.emit_busy)
                begin
                    state_next = ST_RUN;
                    rnd_next   = '0;
                    after_next = AFTER_FIN;
                end
            end
            ST_RUN:
            begin
                rnd_next = rnd_reg + 6'd1;
                if (rnd_reg == LAST_ROUND)
                begin
                    state_next = ST_FOLD;
                end
            end
            ST_FOLD:
            begin
                case (after_reg)
                    AFTER_PAD:
                    begin
                        state_next = ST_PAD;
                    end
                    AFTER_ZERO:
                    begin
                        pw_next    = '0;
                        two_next   = 1'b0;
                        state_next = ST_ZERO;
                    end
                    default:
                    begin
                        state_next = ST_IDLE;
                    end
                endcase
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        in_ready       = state_reg == ST_IDLE;
        cmd.wr_byte    = (state_reg == ST_IDLE) && in_valid && in_byte_valid;
        cmd.pad_word   = state_reg == ST_PAD;
        cmd.zero_word  = (state_reg == ST_ZERO) && (pw_reg < zero_end);
        cmd.len_words  = (state_reg == ST_LEN) && !sts.emit_busy;
        cmd.step       = state_reg == ST_RUN;
        cmd.fold       = state_reg == ST_FOLD;
        cmd.final_fold = (state_reg == ST_FOLD) && (after_reg == AFTER_FIN);
        cmd.rnd        = rnd_reg;
        cmd.word       = pw_reg[3:0];
    end

endmodule

// ----- sv/md5_datapath.sv -----
// md5_datapath: block buffer, chaining words, round unit, length counter, digest buffer.
// Depends on md5_pkg and md5_if (md5_word_if).
module md5_datapath (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic [7:0]           data_byte,
    input  md5_pkg::md5_cmd_t    cmd,
    output md5_pkg::md5_status_t sts,
    md5_word_if.source           digest
);
    import md5_pkg::*;

    logic [3:0][7:0] blk_reg [16];
    logic [31:0]     chain_reg [4];
    logic [31:0]     work_reg [4];
    logic [31:0]     dig_reg [4];
    logic [5:0]      fill_reg;
    logic [60:0]     total_reg;
    logic            emit_busy_reg;
    logic [1:0]      emit_idx_reg;

    logic [31:0] a_src, b_src, c_src, d_src;
    logic [31:0] f_val, sum_val, new_b;
    logic [63:0] bit_len;
    logic        emit_xfer;

    assign bit_len = {total_reg, 3'b000};

    always_comb
    begin
        if (cmd.rnd == '0)
        begin
            a_src = chain_reg[0];
            b_src = chain_reg[1];
            c_src = chain_reg[2];
            d_src = chain_reg[3];
        end
        else
        begin
            a_src = work_reg[0];
            b_src = work_reg[1];
            c_src = work_reg[2];
            d_src = work_reg[3];
        end
        f_val   = md5_round_f(cmd.rnd[5:4], b_src, c_src, d_src);
        sum_val = a_src + f_val + blk_reg[md5_msg_idx(cmd.rnd)] + MD5_K[cmd.rnd];
        new_b   = b_src + md5_rotl(sum_val, md5_rot(cmd.rnd));
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_byte)
        begin
            blk_reg[fill_reg[5:2]][fill_reg[1:0]] <= data_byte;
        end
        if (cmd.pad_word)
        begin
            // lanes below the fill point already hold message bytes
            for (int j = 0; j < 4; j++)
            begin
                if (2'(j) == fill_reg[1:0])
                begin
                    blk_reg[fill_reg[5:2]][j] <= PAD_BYTE;
                end
                else if (2'(j) > fill_reg[1:0])
                begin
                    blk_reg[fill_reg[5:2]][j] <= '0;
                end
            end
        end
        if (cmd.zero_word)
        begin
            blk_reg[cmd.word] <= '0;
        end
        if (cmd.len_words)
        begin
            blk_reg[LEN_LO_WORD] <= bit_len[31:0];
            blk_reg[LEN_HI_WORD] <= bit_len[63:32];
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.step)
        begin
            work_reg[0] <= d_src;
            work_reg[1] <= new_b;
            work_reg[2] <= b_src;
            work_reg[3] <= c_src;
        end
        if (cmd.final_fold)
        begin
            for (int i = 0; i < 4; i++)
            begin
                dig_reg[i] <= chain_reg[i] + work_reg[i];
            end
        end
    end

    assign emit_xfer = digest.valid && digest.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            chain_reg[0]  <= MD5_IV_A;
            chain_reg[1]  <= MD5_IV_B;
            chain_reg[2]  <= MD5_IV_C;
            chain_reg[3]  <= MD5_IV_D;
            fill_reg      <= '0;
            total_reg     <= '0;
            emit_busy_reg <= 1'b0;
            emit_idx_reg  <= '0;
        end
        else
        begin
            if (cmd.wr_byte)
            begin
                fill_reg  <= fill_reg + 6'd1;
                total_reg <= total_reg + 61'd1;
            end
            if (cmd.fold)
            begin
                fill_reg <= '0;
                if (cmd.final_fold)
                begin
                    chain_reg[0]  <= MD5_IV_A;
                    chain_reg[1]  <= MD5_IV_B;
                    chain_reg[2]  <= MD5_IV_C;
                    chain_reg[3]  <= MD5_IV_D;
                    total_reg     <= '0;
                    emit_busy_reg <= 1'b1;
                    emit_idx_reg  <= '0;
                end
                else
                begin
                    for (int i = 0; i < 4; i++)
                    begin
                        chain_reg[i] <= chain_reg[i] + work_reg[i];
                    end
                end
            end
            if (emit_xfer)
            begin
                emit_idx_reg <= emit_idx_reg + 2'd1;
                if (emit_idx_reg == LAST_INDEX)
                begin
                    emit_busy_reg <= 1'b0;
                end
            end
        end
    end

    assign digest.valid       = emit_busy_reg;
    assign digest.digest_word = dig_reg[emit_idx_reg];
    assign digest.word_index  = emit_idx_reg;
    assign digest.last_word   = emit_idx_reg == LAST_INDEX;

    assign sts.fill      = fill_reg;
    assign sts.emit_busy = emit_busy_reg;

endmodule

// ----- sv/md5_checker.sv -----
// md5_checker: port-level assertions for md5_message_digest, attached by bind.
// No package dependency; sees only the top-level channel signals.
module md5_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        in_last,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_word,
    input logic [1:0]  out_index,
    input logic        out_last
);

    a_last_stalls_input: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_ready && in_last) |=> !in_ready)
        else $error("input still ready after end of message");

    a_index_advances: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_ready && !out_last) |=>
            (out_valid && out_index == $past(out_index) + 2'd1))
        else $error("digest words not in sequence");

    a_last_on_fourth: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (out_last == (out_index == 2'd3)))
        else $error("last_word does not match word_index");

    a_start_at_a: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> (out_index == 2'd0))
        else $error("digest does not start with word A");

    a_stall_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && !out_ready) |=> (out_valid && $stable(out_word)))
        else $error("stalled digest word changed");

endmodule

bind md5_message_digest md5_checker u_md5_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (msg.valid),
    .in_ready  (msg.ready),
    .in_last   (msg.last),
    .out_valid (digest.valid),
    .out_ready (digest.ready),
    .out_word  (digest.digest_word),
    .out_index (digest.word_index),
    .out_last  (digest.last_word)
);

// ----- tb/tb_md5_message_digest.sv -----
// tb_md5_message_digest: self-checking bench for the byte-stream MD5 digest block.
// Depends on md5_pkg, md5_if and md5_message_digest; a built-in MD5 predictor
// computes the four digest words of every message and the checker compares each transfer.
module tb_md5_message_digest;
    timeunit 1ns;
    timeprecision 1ps;

    import md5_pkg::*;

    localparam int CYCLE_LIMIT = 400000;
    localparam int LONG_HOLD   = 1500;
    localparam int TAIL_WAIT   = 200;
    localparam int RANDOM_ITEMS = 12;

    localparam logic [31:0] SINE_K [64] = '{
        32'hd76aa478, 32'he8c7b756, 32'h242070db, 32'hc1bdceee,
        32'hf57c0faf, 32'h4787c62a, 32'ha8304613, 32'hfd469501,
        32'h698098d8, 32'h8b44f7af, 32'hffff5bb1, 32'h895cd7be,
        32'h6b901122, 32'hfd987193, 32'ha679438e, 32'h49b40821,
        32'hf61e2562, 32'hc040b340, 32'h265e5a51, 32'he9b6c7aa,
        32'hd62f105d, 32'h02441453, 32'hd8a1e681, 32'he7d3fbc8,
        32'h21e1cde6, 32'hc33707d6, 32'hf4d50d87, 32'h455a14ed,
        32'ha9e3e905, 32'hfcefa3f8, 32'h676f02d9, 32'h8d2a4c8a,
        32'hfffa3942, 32'h8771f681, 32'h6d9d6122, 32'hfde5380c,
        32'ha4beea44, 32'h4bdecfa9, 32'hf6bb4b60, 32'hbebfbc70,
        32'h289b7ec6, 32'heaa127fa, 32'hd4ef3085, 32'h04881d05,
        32'hd9d4d039, 32'he6db99e5, 32'h1fa27cf8, 32'hc4ac5665,
        32'hf4292244, 32'h432aff97, 32'hab9423a7, 32'hfc93a039,
        32'h655b59c3, 32'h8f0ccc92, 32'hffeff47d, 32'h85845dd1,
        32'h6fa87e4f, 32'hfe2ce6e0, 32'ha3014314, 32'h4e0811a1,
        32'hf7537e82, 32'hbd3af235, 32'h2ad7d2bb, 32'heb86d391
    };

    localparam int ROT_AMT [16] = '{7, 12, 17, 22, 5, 9, 14, 20, 4, 11, 16, 23, 6, 10, 15, 21};

    typedef struct packed {
        logic [31:0] word;
        logic [1:0]  index;
        logic        final_word;
    } digest_exp_t;

    logic clk;
    logic rst_n;

    md5_byte_if msg_ch();
    md5_word_if dig_ch();

    md5_message_digest dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .msg    (msg_ch),
        .digest (dig_ch)
    );

    // predictor state
    logic [31:0] hash_state [4];
    logic [31:0] msg_words [16];
    int          held_bytes;
    logic [60:0] msg_len;

    digest_exp_t digest_words_due [$];
    digest_exp_t want;

    int error_count = 0;
    int cycle_count = 0;
    int counted_items = 0;
    bit src_idle_en = 1'b1;
    bit sink_idle_en = 1'b1;
    bit hold_digest_req = 1'b0;

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    function automatic logic [31:0] rotate_left(logic [31:0] x, int n);
        return (x << n) | (x >> (32 - n));
    endfunction

    function automatic void restart_hash();
        hash_state[0] = 32'h67452301;
        hash_state[1] = 32'hefcdab89;
        hash_state[2] = 32'h98badcfe;
        hash_state[3] = 32'h10325476;
        held_bytes = 0;
        msg_len = '0;
    endfunction

    function automatic void store_msg_byte(int pos, logic [7:0] b);
        msg_words[pos / 4][8 * (pos % 4) +: 8] = b;
    endfunction

    function automatic void fold_block();
        logic [31:0] a, b, c, d, f, t;
        int i;
        int g;
        a = hash_state[0];
        b = hash_state[1];
        c = hash_state[2];
        d = hash_state[3];
        for (i = 0; i < 64; i++) begin
            case (i / 16)
                0: begin
                    f = (b & c) | (~b & d);
                    g = i;
                end
                1: begin
                    f = (b & d) | (c & ~d);
                    g = (5 * i + 1) % 16;
                end
                2: begin
                    f = b ^ c ^ d;
                    g = (3 * i + 5) % 16;
                end
                default: begin
                    f = c ^ (b | ~d);
                    g = (7 * i) % 16;
                end
            endcase
            t = d;
            d = c;
            c = b;
            b = b + rotate_left(a + f + msg_words[g] + SINE_K[i], ROT_AMT[(i / 16) * 4 + i % 4]);
            a = t;
        end
        hash_state[0] = hash_state[0] + a;
        hash_state[1] = hash_state[1] + b;
        hash_state[2] = hash_state[2] + c;
        hash_state[3] = hash_state[3] + d;
        held_bytes = 0;
    endfunction

    function automatic void md5_predict_item(logic [7:0] data, logic has_byte, logic is_last);
        logic [63:0] bit_len;
        int pos;
        int k;
        digest_exp_t e;
        if (has_byte)
        begin
            store_msg_byte(held_bytes, data);
            msg_len = msg_len + 1'b1;
            held_bytes++;
            if (held_bytes == 64)
                fold_block();
        end
        if (!is_last)
            return;
        bit_len = {msg_len, 3'b000};
        store_msg_byte(held_bytes, PAD_BYTE);
        pos = held_bytes + 1;
        if (pos > 56)
        begin
            while (pos < 64)
            begin
                store_msg_byte(pos, 8'h00);
                pos++;
            end
            fold_block();
            pos = 0;
        end
        while (pos < 56)
        begin
            store_msg_byte(pos, 8'h00);
            pos++;
        end
        msg_words[14] = bit_len[31:0];
        msg_words[15] = bit_len[63:32];
        fold_block();
        for (k = 0; k < 4; k++)
        begin
            e.word = hash_state[k];
            e.index = 2'(k);
            e.final_word = (2'(k) == LAST_INDEX);
            digest_words_due.push_back(e);
        end
        restart_hash();
    endfunction

    // digest checker
    always @(posedge clk)
    begin
        if (rst_n === 1'b1 && dig_ch.valid === 1'b1 && dig_ch.ready === 1'b1)
        begin
            if (digest_words_due.size() == 0)
            begin
                $display("%0t unexpected digest transfer: expected none, actual word %h index %0d",
                         $time, dig_ch.digest_word, dig_ch.word_index);
                error_count++;
            end
            else
            begin
                want = digest_words_due.pop_front();
                if (dig_ch.digest_word !== want.word)
                begin
                    $display("%0t digest_word mismatch: expected %h, actual %h",
                             $time, want.word, dig_ch.digest_word);
                    error_count++;
                end
                if (dig_ch.word_index !== want.index)
                begin
                    $display("%0t word_index mismatch: expected %0d, actual %0d",
                             $time, want.index, dig_ch.word_index);
                    error_count++;
                end
                if (dig_ch.last_word !== want.final_word)
                begin
                    $display("%0t last_word mismatch: expected %b, actual %b",
                             $time, want.final_word, dig_ch.last_word);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // digest side pacing; the long hold is requested by the backpressure test
    initial begin : digest_pacing
        int n;
        dig_ch.ready <= 1'b0;
        wait (rst_n === 1'b1);
        @(posedge clk);
        forever
        begin
            if (hold_digest_req)
            begin
                hold_digest_req = 1'b0;
                dig_ch.ready <= 1'b0;
                n = LONG_HOLD;
            end
            else if (sink_idle_en && $urandom_range(0, 2) == 0)
            begin
                dig_ch.ready <= 1'b0;
                n = $urandom_range(1, 18);
            end
            else
            begin
                dig_ch.ready <= 1'b1;
                n = $urandom_range(1, 30);
            end
            repeat (n) @(posedge clk);
        end
    end

    task automatic send_item(logic [7:0] data, logic has_byte, logic is_last);
        if (src_idle_en && $urandom_range(0, 5) == 0)
        begin
            msg_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 18)) @(posedge clk);
        end
        msg_ch.valid      <= 1'b1;
        msg_ch.data_byte  <= data;
        msg_ch.byte_valid <= has_byte;
        msg_ch.last       <= is_last;
        do
            @(posedge clk);
        while (msg_ch.ready !== 1'b1);
        md5_predict_item(data, has_byte, is_last);
        if (has_byte || is_last)
            counted_items++;
    endtask

    task automatic send_message(int n_bytes, bit end_alone, bit noisy);
        int i;
        for (i = 0; i < n_bytes; i++)
        begin
            if (noisy && $urandom_range(0, 9) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_item(8'($urandom), 1'b1, !end_alone && i == n_bytes - 1);
        end
        if (end_alone || n_bytes == 0)
            send_item(8'($urandom), 1'b0, 1'b1);
    endtask

    task automatic wait_digests_drained();
        msg_ch.valid <= 1'b0;
        do
            @(posedge clk);
        while (digest_words_due.size() != 0);
    endtask

    task automatic test_short_messages();
        send_item(8'hA5, 1'b0, 1'b0);
        send_item(8'h5A, 1'b0, 1'b0);
        send_item(8'h00, 1'b0, 1'b1);
        send_item(8'hFF, 1'b0, 1'b1);
        send_item(8'h00, 1'b1, 1'b1);
        send_item(8'hFF, 1'b1, 1'b1);
        send_item(8'h61, 1'b1, 1'b0);
        send_item(8'h62, 1'b1, 1'b0);
        send_item(8'h63, 1'b1, 1'b1);
        send_item(8'h80, 1'b1, 1'b0);
        send_item(8'h7F, 1'b0, 1'b0);
        send_item(8'h01, 1'b1, 1'b0);
        send_item(8'hFE, 1'b0, 1'b1);
    endtask

    // last byte completes a block: compression, then a full padding block
    task automatic test_block_edges();
        send_message(64, 1'b0, 1'b0);
    endtask

    task automatic test_backpressure();
        int m;
        hold_digest_req = 1'b1;
        for (m = 0; m < 5; m++)
            send_message($urandom_range(0, 3), 1'b0, 1'b0);
        wait_digests_drained();
    endtask

    task automatic test_random_traffic();
        int target;
        int n;
        target = counted_items + RANDOM_ITEMS;
        while (counted_items < target)
        begin
            n = $urandom_range(0, 6);
            if ($urandom_range(0, 7) == 0)
                send_item(8'($urandom), 1'b0, 1'b0);
            send_message(n, $urandom_range(0, 3) == 0, 1'b1);
        end
    endtask

    task automatic test_steady_stream();
        int m;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (m = 0; m < 4; m++)
            send_message($urandom_range(0, 4), $urandom_range(0, 1) == 1, 1'b0);
    endtask

    initial begin
        rst_n             <= 1'b0;
        msg_ch.valid      <= 1'b0;
        msg_ch.data_byte  <= 8'h00;
        msg_ch.byte_valid <= 1'b0;
        msg_ch.last       <= 1'b0;
        restart_hash();
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_short_messages();
        test_block_edges();
        test_backpressure();
        test_random_traffic();
        test_steady_stream();
        wait_digests_drained();
        repeat (TAIL_WAIT) @(posedge clk);
        if (error_count == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ----- md5_message_digest.f -----
sv/md5_pkg.sv
sv/md5_if.sv
sv/md5_ctrl.sv
sv/md5_datapath.sv
sv/md5_message_digest.sv
sv/md5_checker.sv
tb/tb_md5_message_digest.sv
